>>> rtl/edge_reservoir_sampler_core_macros.svh
// ---------------------------------------------------------------------------
// Edge reservoir sampler assertion macros
// Concurrent assertion wrappers that compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef EDGE_RESERVOIR_SAMPLER_CORE_MACROS_SVH
`define EDGE_RESERVOIR_SAMPLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ERS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ERS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ERS_ASSERT_IMPL(label, ante, cons)
`define ERS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/ers_pkg.sv
// ---------------------------------------------------------------------------
// Edge reservoir sampler package
// Widths, command and status types, and back-end state encoding.
// ---------------------------------------------------------------------------
`default_nettype none

package ers_pkg;

	localparam int MAX_SLOTS  = 1024;
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int NODE_W     = 31;
	localparam int RND_W      = 32;
	localparam int SEEN_W     = 32;
	localparam int CAP_W      = 11;
	localparam int CAP_RESET  = 1024;
	localparam int SLOT_OUT_W = 10;
	localparam int ENTRY_W    = 1 + 2 * NODE_W;
	localparam int DIV_STEPS  = RND_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic              fill;
		logic [NODE_W-1:0] u;
		logic [NODE_W-1:0] v;
		logic [RND_W-1:0]  rnd;
		logic [SEEN_W-1:0] seen;
		logic [SEEN_W-1:0] seen_next;
		logic [CAP_W-1:0]  cap;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_PICK,
		BK_READ,
		BK_DONE
	} back_state_t;

endpackage

`default_nettype wire

>>> rtl/ers_if.sv
// ---------------------------------------------------------------------------
// Edge reservoir sampler channel interfaces
// Valid/ready channels for offered edges and for sampling results.
// ---------------------------------------------------------------------------
`default_nettype none

interface ers_in_if;
	import ers_pkg::*;

	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] edge_u;
	logic [NODE_W-1:0] edge_v;
	logic [RND_W-1:0]  random_word;

	modport source (output valid, output edge_u, output edge_v, output random_word,
		input ready);
	modport sink (input valid, input edge_u, input edge_v, input random_word,
		output ready);
endinterface

interface ers_out_if;
	import ers_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  accepted;
	logic [SLOT_OUT_W-1:0] slot;
	logic                  evicted_valid;
	logic [NODE_W-1:0]     evicted_u;
	logic [NODE_W-1:0]     evicted_v;
	logic [SEEN_W-1:0]     seen_count;

	modport source (output valid, output accepted, output slot, output evicted_valid,
		output evicted_u, output evicted_v, output seen_count, input ready);
	modport sink (input valid, input accepted, input slot, input evicted_valid,
		input evicted_u, input evicted_v, input seen_count, output ready);
endinterface

`default_nettype wire

>>> rtl/ers_queue.sv
// ---------------------------------------------------------------------------
// Edge reservoir sampler command queue
// Two-entry FIFO that decouples the classifying front from the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module ers_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ers_pkg::cmd_t    push_cmd,
	input  wire logic             pop,
	output ers_pkg::cmd_t         head,
	output ers_pkg::q_stat_t      qs
);
	import ers_pkg::*;

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign qs.empty = (cnt_q == '0);
	assign qs.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign do_push  = push && !qs.full;
	assign do_pop   = pop && !qs.empty;
	assign head     = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

>>> rtl/ers_front.sv
// ---------------------------------------------------------------------------
// Edge reservoir sampler front end
// Holds capacity and the edge count, and classifies each edge as fill or sample.
// ---------------------------------------------------------------------------
`default_nettype none

module ers_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [ers_pkg::CAP_W-1:0] cfg_wdata,
	ers_in_if.sink                         edges,
	input  wire ers_pkg::q_stat_t          qs,
	output logic                           push,
	output ers_pkg::cmd_t                  push_cmd
);
	import ers_pkg::*;

	logic [CAP_W-1:0]  cap_q;
	logic [SEEN_W-1:0] seen_q;
	logic [CAP_W-1:0]  cap_eff;
	logic [SEEN_W-1:0] seen_next;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (SEEN_W'(cap_q) > SEEN_W'(MAX_SLOTS)) begin
			cap_eff = CAP_W'(MAX_SLOTS);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign seen_next   = (seen_q == '1) ? seen_q : seen_q + 1'b1;
	assign edges.ready = !qs.full;
	assign push        = edges.valid && edges.ready;

	assign push_cmd.fill      = (seen_q < SEEN_W'(cap_eff));
	assign push_cmd.u         = edges.edge_u;
	assign push_cmd.v         = edges.edge_v;
	assign push_cmd.rnd       = edges.random_word;
	assign push_cmd.seen      = seen_q;
	assign push_cmd.seen_next = seen_next;
	assign push_cmd.cap       = cap_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_W'(CAP_RESET);
			seen_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (push) begin
				seen_q <= seen_next;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/ers_back.sv
// ---------------------------------------------------------------------------
// Edge reservoir sampler back end
// Reduces the random word modulo the count, updates the reservoir and reports.
// ---------------------------------------------------------------------------
`default_nettype none

module ers_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ers_pkg::cmd_t    head,
	input  wire ers_pkg::q_stat_t qs,
	output logic                  pop,
	ers_out_if.source             results
);
	import ers_pkg::*;

	back_state_t          st_q;
	back_state_t          st_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_v_q;

	cmd_t                 cmd_q;
	logic [SEEN_W:0]      divisor_q;
	logic [SEEN_W:0]      rem_q;
	logic [RND_W-1:0]     dvd_q;
	logic [SLOT_W-1:0]    idx_q;
	logic                 take_q;
	logic [ENTRY_W-1:0]   rd_q;
	logic [ENTRY_W-1:0]   mem [MAX_SLOTS];

	logic                  acc_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic                  ev_v_q;
	logic [NODE_W-1:0]     ev_u_q;
	logic [NODE_W-1:0]     ev_w_q;
	logic [SEEN_W-1:0]     cnt_out_q;

	logic                 div_en;
	logic                 pick_en;
	logic                 rd_en;
	logic                 fire;
	logic                 last;
	logic                 rem_lt_cap;
	logic                 evict;
	logic [SEEN_W+1:0]    trial;
	logic [SEEN_W+1:0]    dvs_ext;
	logic                 ge;

	assign last       = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign rem_lt_cap = (rem_q < (SEEN_W + 1)'(cmd_q.cap));
	assign trial      = {rem_q, dvd_q[RND_W-1]};
	assign dvs_ext    = {1'b0, divisor_q};
	assign ge         = (trial >= dvs_ext);

	// A fill slot has never been written, so only a replacement can evict.
	assign evict      = take_q && !cmd_q.fill;

	always_comb begin
		st_d    = st_q;
		pop     = 1'b0;
		div_en  = 1'b0;
		pick_en = 1'b0;
		rd_en   = 1'b0;
		fire    = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (!qs.empty) begin
					pop  = 1'b1;
					st_d = head.fill ? BK_READ : BK_DIV;
				end
			end
			BK_DIV: begin
				div_en = 1'b1;
				if (last) begin
					st_d = BK_PICK;
				end
			end
			BK_PICK: begin
				pick_en = 1'b1;
				st_d    = rem_lt_cap ? BK_READ : BK_DONE;
			end
			BK_READ: begin
				rd_en = 1'b1;
				st_d  = BK_DONE;
			end
			BK_DONE: begin
				if (!out_v_q || results.ready) begin
					fire = 1'b1;
					st_d = BK_IDLE;
				end
			end
			default: begin
				st_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= BK_IDLE;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pop) begin
				cnt_q <= '0;
			end else if (div_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q     <= head;
			idx_q     <= head.seen[SLOT_W-1:0];
			take_q    <= head.fill;
			divisor_q <= {1'b0, head.seen} + (SEEN_W + 1)'(1);
			rem_q     <= '0;
			dvd_q     <= head.rnd;
		end
		if (div_en) begin
			rem_q <= ge ? (SEEN_W + 1)'(trial - dvs_ext) : (SEEN_W + 1)'(trial);
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
		end
		if (pick_en) begin
			take_q <= rem_lt_cap;
			idx_q  <= rem_q[SLOT_W-1:0];
		end
		if (fire) begin
			acc_q     <= take_q;
			slot_q    <= take_q ? SLOT_OUT_W'(idx_q) : '0;
			ev_v_q    <= evict && rd_q[ENTRY_W-1];
			ev_u_q    <= evict ? rd_q[2*NODE_W-1:NODE_W] : '0;
			ev_w_q    <= evict ? rd_q[NODE_W-1:0] : '0;
			cnt_out_q <= cmd_q.seen_next;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[idx_q];
		end
		if (fire && take_q) begin
			mem[idx_q] <= {1'b1, cmd_q.u, cmd_q.v};
		end
	end

	assign results.valid         = out_v_q;
	assign results.accepted      = acc_q;
	assign results.slot          = slot_q;
	assign results.evicted_valid = ev_v_q;
	assign results.evicted_u     = ev_u_q;
	assign results.evicted_v     = ev_w_q;
	assign results.seen_count    = cnt_out_q;

endmodule

`default_nettype wire

>>> rtl/edge_reservoir_sampler_core.sv
// ---------------------------------------------------------------------------
// Edge reservoir sampler core
// Keeps a uniform random sample of a stream of edges in an on-chip reservoir.
// ---------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  edges     in         edge_u, edge_v, random_word
//  results   out        accepted, slot, evicted edge, seen_count
//  cfg       in         capacity (write only)
//
// An edge in the fill phase passes the back end through a read and a done state; any
// later edge first runs the restoring divider, which produces one remainder bit per
// cycle, then a pick state, and a read state only when it is kept. A two-entry queue lets the front take
// edges while the back end works, and a result register holds a beat under a stall.
// Reset clears the count and sets the capacity to 1024; the memory is not cleared.
`default_nettype none
`include "edge_reservoir_sampler_core_macros.svh"

module edge_reservoir_sampler_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [ers_pkg::CAP_W-1:0] cfg_wdata,
	ers_in_if.sink                         edges,
	ers_out_if.source                      results
);
	import ers_pkg::*;

	logic    push;
	logic    pop;
	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t qs;

	ers_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.edges     (edges),
		.qs        (qs),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	ers_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qs       (qs)
	);

	ers_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qs      (qs),
		.pop     (pop),
		.results (results)
	);

	`ERS_ASSERT_NEXT(a_push_fills_queue, push, !qs.empty)
	`ERS_ASSERT_IMPL(a_seen_nonzero, results.valid, results.seen_count != '0)
	`ERS_ASSERT_IMPL(a_reject_clean, results.valid && !results.accepted, results.slot == '0 && !results.evicted_valid)

endmodule

`default_nettype wire
